@@ design/bbfr_pkg.sv @@
// bbfr_pkg: shared types and constants of the barcode frame reader
// pixel and result payloads, queue entry of a classified pixel, register indexes
// no dependencies
`timescale 1ns / 1ps

package bbfr_pkg;

    localparam int GRID_SIZE_DEF = 8;
    localparam int BLOCK_LEN_DEF = 10;
    localparam int IDX_W         = 3;
    localparam int BIT_W         = 6;
    localparam int SUM_W         = 22;
    localparam int CFG_W         = 13;
    localparam int VALUE_W       = 10;
    localparam int CODE_W        = 64;
    localparam int OP_DEPTH      = 4;
    localparam int RES_DEPTH     = 2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST    = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST   = 13'd480;
    localparam logic [7:0]       DARK_THRESHOLD_RST = 8'd128;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_DARK_THRESHOLD
    } reg_index_t;

    typedef struct packed {
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        frame_end;
    } pixel_t;

    typedef struct packed {
        logic [CODE_W-1:0] upper_left_code;
        logic [CODE_W-1:0] lower_right_code;
    } code_t;

    typedef struct packed {
        logic             hit;
        logic             start;
        logic             last;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } grid_op_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        grid_op_t           upper;
        grid_op_t           lower;
        logic               frame_end;
    } op_t;

endpackage

@@ design/bbfr_fifo.sv @@
// bbfr_fifo: small register queue with push/full and pop/empty sides
// used between front and back, and for finished results; no package needed
`timescale 1ns / 1ps

module bbfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ design/bbfr_front.sv @@
// bbfr_front: input register and pixel classification against both grids
// depends on bbfr_pkg for pixel_t, op_t and grid_op_t
`timescale 1ns / 1ps

module bbfr_front #(
    parameter int GRID_SIZE = 8,
    parameter int BLOCK_LEN = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  bbfr_pkg::pixel_t         pixel,
    output logic                     full,
    input  logic [bbfr_pkg::CFG_W-1:0] frame_width,
    input  logic [bbfr_pkg::CFG_W-1:0] frame_height,
    output logic                     op_push,
    output bbfr_pkg::op_t            op,
    input  logic                     op_full
);

    import bbfr_pkg::*;

    localparam int SPAN = GRID_SIZE * BLOCK_LEN;

    pixel_t           pix_reg;
    logic             pix_valid_reg, pix_valid_next;
    logic             accept;
    logic             lower_ok;
    logic [CFG_W-1:0] x_ext;
    logic [CFG_W-1:0] y_ext;
    logic [CFG_W-1:0] ox;
    logic [CFG_W-1:0] oy;

    function automatic grid_op_t locate(input logic ok, input logic [CFG_W-1:0] dx,
                                        input logic [CFG_W-1:0] dy);
        grid_op_t         g;
        logic [IDX_W-1:0] col;
        logic [IDX_W-1:0] row;
        logic [CFG_W-1:0] rx;
        logic [CFG_W-1:0] ry;
        col = '0;
        row = '0;
        for (int k = 1; k < GRID_SIZE; k++)
        begin
            if (dx >= CFG_W'(k * BLOCK_LEN))
            begin
                col = col + 1'b1;
            end
            if (dy >= CFG_W'(k * BLOCK_LEN))
            begin
                row = row + 1'b1;
            end
        end
        rx      = dx - CFG_W'(col) * CFG_W'(BLOCK_LEN);
        ry      = dy - CFG_W'(row) * CFG_W'(BLOCK_LEN);
        g.hit   = ok && (dx < CFG_W'(SPAN)) && (dy < CFG_W'(SPAN));
        g.start = (rx == '0) && (ry == '0);
        g.last  = (rx == CFG_W'(BLOCK_LEN - 1)) && (ry == CFG_W'(BLOCK_LEN - 1));
        g.row   = row;
        g.col   = col;
        return g;
    endfunction

    assign full    = pix_valid_reg && op_full;
    assign accept  = push && !full;
    assign op_push = pix_valid_reg;

    assign x_ext = {1'b0, pix_reg.pixel_x};
    assign y_ext = {1'b0, pix_reg.pixel_y};
    assign ox    = frame_width - CFG_W'(SPAN);
    assign oy    = frame_height - CFG_W'(SPAN);
    assign lower_ok = (frame_width >= CFG_W'(SPAN)) && (frame_height >= CFG_W'(SPAN))
                      && (x_ext >= ox) && (y_ext >= oy);

    always_comb
    begin
        op.value     = VALUE_W'(pix_reg.red) + VALUE_W'(pix_reg.green)
                       + VALUE_W'(pix_reg.blue);
        op.upper     = locate(1'b1, x_ext, y_ext);
        op.lower     = locate(lower_ok, x_ext - ox, y_ext - oy);
        op.frame_end = pix_reg.frame_end;
    end

    always_comb
    begin
        pix_valid_next = pix_valid_reg;
        if (accept)
        begin
            pix_valid_next = 1'b1;
        end
        else if (pix_valid_reg && !op_full)
        begin
            pix_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= pixel;
        end
    end

endmodule

@@ design/bbfr_back.sv @@
// bbfr_back: block sums, dark compare and code bits for both grids
// depends on bbfr_pkg for op_t and code_t
`timescale 1ns / 1ps

module bbfr_back #(
    parameter int GRID_SIZE = 8,
    parameter int BLOCK_LEN = 10
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [7:0]     dark_threshold,
    input  logic           op_empty,
    input  bbfr_pkg::op_t  op,
    output logic           op_pop,
    output logic           res_push,
    output bbfr_pkg::code_t res,
    input  logic           res_full
);

    import bbfr_pkg::*;

    localparam int AREA3 = 3 * BLOCK_LEN * BLOCK_LEN;

    logic [SUM_W-1:0]  upper_sums_reg [GRID_SIZE];
    logic [SUM_W-1:0]  lower_sums_reg [GRID_SIZE];
    logic [CODE_W-1:0] upper_code_reg, upper_code_next;
    logic [CODE_W-1:0] lower_code_reg, lower_code_next;
    logic [SUM_W-1:0]  limit_reg;
    logic [SUM_W-1:0]  up_sum;
    logic [SUM_W-1:0]  lo_sum;
    logic [CODE_W-1:0] up_bit;
    logic [CODE_W-1:0] lo_bit;
    logic              go;

    function automatic logic [BIT_W-1:0] bit_index(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return BIT_W'(row) * BIT_W'(GRID_SIZE) + BIT_W'(col);
    endfunction

    assign go       = !op_empty && (!op.frame_end || !res_full);
    assign op_pop   = go;
    assign res_push = go && op.frame_end;

    always_comb
    begin
        up_sum = (op.upper.start ? '0 : upper_sums_reg[op.upper.col]) + SUM_W'(op.value);
        lo_sum = (op.lower.start ? '0 : lower_sums_reg[op.lower.col]) + SUM_W'(op.value);
        up_bit = '0;
        lo_bit = '0;
        if (op.upper.hit && op.upper.last && (up_sum < limit_reg))
        begin
            up_bit = CODE_W'(1) << bit_index(op.upper.row, op.upper.col);
        end
        if (op.lower.hit && op.lower.last && (lo_sum < limit_reg))
        begin
            lo_bit = CODE_W'(1) << bit_index(op.lower.row, op.lower.col);
        end
        res.upper_left_code  = upper_code_reg | up_bit;
        res.lower_right_code = lower_code_reg | lo_bit;
        upper_code_next = upper_code_reg;
        lower_code_next = lower_code_reg;
        if (go)
        begin
            upper_code_next = op.frame_end ? '0 : res.upper_left_code;
            lower_code_next = op.frame_end ? '0 : res.lower_right_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_code_reg <= '0;
            lower_code_reg <= '0;
            limit_reg      <= SUM_W'(DARK_THRESHOLD_RST) * SUM_W'(AREA3);
        end
        else
        begin
            upper_code_reg <= upper_code_next;
            lower_code_reg <= lower_code_next;
            limit_reg      <= SUM_W'(dark_threshold) * SUM_W'(AREA3);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && op.upper.hit)
        begin
            upper_sums_reg[op.upper.col] <= up_sum;
        end
        if (go && op.lower.hit)
        begin
            lower_sums_reg[op.lower.col] <= lo_sum;
        end
    end

endmodule

@@ design/block_barcode_frame_reader.sv @@
// block_barcode_frame_reader: top level, configuration registers and queues
// depends on bbfr_pkg, bbfr_front, bbfr_fifo and bbfr_back
// one pixel per cycle sustained while the input is not stalled; the frame-end result
// passes through the input register, the classify queue and the result queue
// a full result queue holds frame-end pixels back and stalls the input behind them
// reset: sizes 640 x 480, threshold 128, codes zero, queues empty, block sums undefined
`timescale 1ns / 1ps

module block_barcode_frame_reader #(
    parameter int GRID_SIZE = bbfr_pkg::GRID_SIZE_DEF,
    parameter int BLOCK_LEN = bbfr_pkg::BLOCK_LEN_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bbfr_pkg::pixel_t           pixel,
    output logic                       full,
    output logic                       empty,
    input  logic                       pop,
    output bbfr_pkg::code_t            result,
    input  logic                       wr_en,
    input  logic [1:0]                 wr_index,
    input  logic [bbfr_pkg::CFG_W-1:0] wr_data
);

    import bbfr_pkg::*;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic [7:0]       dark_threshold_reg;
    op_t              front_op;
    op_t              back_op;
    logic             op_push;
    logic             op_full;
    logic             op_pop;
    logic             op_empty;
    code_t            back_res;
    logic             res_push;
    logic             res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg    <= FRAME_WIDTH_RST;
            frame_height_reg   <= FRAME_HEIGHT_RST;
            dark_threshold_reg <= DARK_THRESHOLD_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_WIDTH:    frame_width_reg    <= wr_data;
                REG_FRAME_HEIGHT:   frame_height_reg   <= wr_data;
                REG_DARK_THRESHOLD: dark_threshold_reg <= wr_data[7:0];
                default:            ;
            endcase
        end
    end

    bbfr_front #(
        .GRID_SIZE(GRID_SIZE),
        .BLOCK_LEN(BLOCK_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .pixel       (pixel),
        .full        (full),
        .frame_width (frame_width_reg),
        .frame_height(frame_height_reg),
        .op_push     (op_push),
        .op          (front_op),
        .op_full     (op_full)
    );

    bbfr_fifo #(
        .WIDTH($bits(op_t)),
        .DEPTH(OP_DEPTH)
    ) u_op_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (op_push),
        .wdata(front_op),
        .full (op_full),
        .pop  (op_pop),
        .rdata(back_op),
        .empty(op_empty)
    );

    bbfr_back #(
        .GRID_SIZE(GRID_SIZE),
        .BLOCK_LEN(BLOCK_LEN)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .dark_threshold(dark_threshold_reg),
        .op_empty      (op_empty),
        .op            (back_op),
        .op_pop        (op_pop),
        .res_push      (res_push),
        .res           (back_res),
        .res_full      (res_full)
    );

    bbfr_fifo #(
        .WIDTH($bits(code_t)),
        .DEPTH(RES_DEPTH)
    ) u_res_queue (
        .clk  (clk),
        .rst_n(rst_n),
        .push (res_push),
        .wdata(back_res),
        .full (res_full),
        .pop  (pop),
        .rdata(result),
        .empty(empty)
    );

endmodule
